/* hw/rtl/tts_pkg.sv */
package tts_pkg;

    // Coordinate width of every vertex and trapezoid y (signed, Q12.4).
    localparam int COORD_BITS = 16;

    // Original vertex index as carried on the edge fields.
    typedef logic [1:0] vidx_t;

    localparam vidx_t VTX_FIRST  = 2'd0;
    localparam vidx_t VTX_SECOND = 2'd1;
    localparam vidx_t VTX_THIRD  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One input word: the three screen vertices.
    typedef struct packed {
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
        coord_t third_x;
        coord_t third_y;
    } tri_in_t;

    // One result word: a trapezoid bounded by a left and a right edge.
    typedef struct packed {
        coord_t top_y;
        coord_t bottom_y;
        vidx_t  left_start;
        vidx_t  left_end;
        vidx_t  right_start;
        vidx_t  right_end;
        logic   last;
    } trap_t;

endpackage

/* hw/rtl/triangle_trapezoid_split.sv */
// Triangle to trapezoid split. A triangle word is taken when start is high
// and busy is low; it passes the input register, the sorted stage and the
// result register, and its first trapezoid appears on trap with trap_valid
// high for exactly one cycle. Degenerate triangles (all y equal or all x
// equal) give no word, flat-top and flat-bottom triangles give one, and all
// others give two on consecutive cycles, the second one marked by last. The
// receiver cannot stall: every strobed word must be taken in that cycle. A
// triangle enters every cycle while the result port is free; a triangle that
// splits in two holds the result port while its second word is pending, so a
// stream of such triangles stalls the input. That single result port is the only thing that raises busy.
module triangle_trapezoid_split
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tts_pkg::tri_in_t vertices,
    output logic             trap_valid,
    output tts_pkg::trap_t   trap
);

    localparam int CW = tts_pkg::COORD_BITS;

    typedef struct packed {
        tts_pkg::coord_t x;
        tts_pkg::coord_t y;
        tts_pkg::vidx_t  idx;
    } vertex_t;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_FLAT_TOP,
        KIND_FLAT_BOTTOM,
        KIND_SPLIT
    } kind_t;

    typedef logic signed [CW:0]     diff_t;
    typedef logic signed [2*CW+1:0] prod_t;

    // Input stage.
    logic             in_valid_reg;
    tts_pkg::tri_in_t in_reg;

    // Sorted stage.
    logic    srt_valid_reg;
    kind_t   srt_kind_reg,  srt_kind_next;
    vertex_t srt_top_reg,   srt_top_next;
    vertex_t srt_mid_reg,   srt_mid_next;
    vertex_t srt_bot_reg,   srt_bot_next;
    diff_t   dxb_reg, dxb_next;
    diff_t   dyc_reg, dyc_next;
    diff_t   dxc_reg, dxc_next;
    diff_t   dyb_reg, dyb_next;

    // Result stage with one pending word for the second trapezoid.
    logic           trap_valid_reg;
    tts_pkg::trap_t trap_reg;
    logic           pend_valid_reg;
    tts_pkg::trap_t pend_reg;

    logic accept;
    logic srt_free;
    logic emit_first;

    // Handshake: the sorted stage frees up unless a pending word blocks it.
    assign srt_free   = !srt_valid_reg || !pend_valid_reg;
    assign busy       = in_valid_reg && !srt_free;
    assign accept     = start && !busy;
    assign trap_valid = trap_valid_reg;
    assign trap       = trap_reg;

    // Sort by y with three compare-and-swap steps, then classify.
    always_comb
    begin
        vertex_t p;
        vertex_t q;
        vertex_t r;
        vertex_t t;
        logic    all_y_eq;
        logic    all_x_eq;

        t     = '0;
        p.x   = in_reg.first_x;
        p.y   = in_reg.first_y;
        p.idx = tts_pkg::VTX_FIRST;
        q.x   = in_reg.second_x;
        q.y   = in_reg.second_y;
        q.idx = tts_pkg::VTX_SECOND;
        r.x   = in_reg.third_x;
        r.y   = in_reg.third_y;
        r.idx = tts_pkg::VTX_THIRD;

        // Swap only on strictly greater y; equal y need not keep input order.
        if (p.y > q.y)
        begin
            t = p; p = q; q = t;
        end
        if (p.y > r.y)
        begin
            t = p; p = r; r = t;
        end
        if (q.y > r.y)
        begin
            t = q; q = r; r = t;
        end

        all_y_eq = (in_reg.first_y == in_reg.second_y) && (in_reg.second_y == in_reg.third_y);
        all_x_eq = (in_reg.first_x == in_reg.second_x) && (in_reg.second_x == in_reg.third_x);

        if (all_y_eq || all_x_eq)
        begin
            srt_kind_next = KIND_DROP;
        end
        else if (p.y == q.y)
        begin
            // Flat top: order the two upper vertices by x.
            srt_kind_next = KIND_FLAT_TOP;
            if (p.x > q.x)
            begin
                t = p; p = q; q = t;
            end
        end
        else if (q.y == r.y)
        begin
            // Flat bottom: order the two lower vertices by x.
            srt_kind_next = KIND_FLAT_BOTTOM;
            if (q.x > r.x)
            begin
                t = q; q = r; r = t;
            end
        end
        else
        begin
            srt_kind_next = KIND_SPLIT;
        end

        srt_top_next = p;
        srt_mid_next = q;
        srt_bot_next = r;

        // Edge deltas for the side test of the middle vertex.
        dxb_next = diff_t'({q.x[CW-1], q.x}) - diff_t'({p.x[CW-1], p.x});
        dyc_next = diff_t'({r.y[CW-1], r.y}) - diff_t'({p.y[CW-1], p.y});
        dxc_next = diff_t'({r.x[CW-1], r.x}) - diff_t'({p.x[CW-1], p.x});
        dyb_next = diff_t'({q.y[CW-1], q.y}) - diff_t'({p.y[CW-1], p.y});
    end

    // Side test and trapezoid assembly.
    prod_t          lhs_prod;
    prod_t          rhs_prod;
    logic           mid_left;
    logic           two_words;
    tts_pkg::trap_t first_word;
    tts_pkg::trap_t second_word;

    assign lhs_prod = dxb_reg * dyc_reg;
    assign rhs_prod = dxc_reg * dyb_reg;
    // Exact cross-multiplied compare; collinear counts as left.
    assign mid_left = (lhs_prod <= rhs_prod);

    always_comb
    begin
        first_word  = '0;
        second_word = '0;
        two_words   = 1'b0;
        case (srt_kind_reg)
            KIND_FLAT_TOP:
            begin
                first_word = '{srt_top_reg.y, srt_bot_reg.y, srt_top_reg.idx,
                               srt_bot_reg.idx, srt_mid_reg.idx, srt_bot_reg.idx, 1'b1};
            end
            KIND_FLAT_BOTTOM:
            begin
                first_word = '{srt_top_reg.y, srt_bot_reg.y, srt_top_reg.idx,
                               srt_mid_reg.idx, srt_top_reg.idx, srt_bot_reg.idx, 1'b1};
            end
            KIND_SPLIT:
            begin
                two_words = 1'b1;
                if (mid_left)
                begin
                    first_word  = '{srt_top_reg.y, srt_mid_reg.y, srt_top_reg.idx,
                                    srt_mid_reg.idx, srt_top_reg.idx, srt_bot_reg.idx, 1'b0};
                    second_word = '{srt_mid_reg.y, srt_bot_reg.y, srt_mid_reg.idx,
                                    srt_bot_reg.idx, srt_top_reg.idx, srt_bot_reg.idx, 1'b1};
                end
                else
                begin
                    first_word  = '{srt_top_reg.y, srt_mid_reg.y, srt_top_reg.idx,
                                    srt_bot_reg.idx, srt_top_reg.idx, srt_mid_reg.idx, 1'b0};
                    second_word = '{srt_mid_reg.y, srt_bot_reg.y, srt_top_reg.idx,
                                    srt_bot_reg.idx, srt_mid_reg.idx, srt_bot_reg.idx, 1'b1};
                end
            end
            default:
            begin
                first_word  = '0;
                second_word = '0;
                two_words   = 1'b0;
            end
        endcase
    end

    assign emit_first = srt_valid_reg && !pend_valid_reg && (srt_kind_reg != KIND_DROP);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            srt_valid_reg  <= 1'b0;
            trap_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= accept || busy;
            if (srt_free)
            begin
                srt_valid_reg <= in_valid_reg;
            end
            trap_valid_reg <= emit_first || pend_valid_reg;
            pend_valid_reg <= emit_first && two_words;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= vertices;
        end
        if (srt_free)
        begin
            srt_kind_reg <= srt_kind_next;
            srt_top_reg  <= srt_top_next;
            srt_mid_reg  <= srt_mid_next;
            srt_bot_reg  <= srt_bot_next;
            dxb_reg      <= dxb_next;
            dyc_reg      <= dyc_next;
            dxc_reg      <= dxc_next;
            dyb_reg      <= dyb_next;
        end
        trap_reg <= pend_valid_reg ? pend_reg : first_word;
        if (emit_first)
        begin
            pend_reg <= second_word;
        end
    end

    // A pending second word is always shown in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |=> (trap_valid && trap.last && !pend_valid_reg))
        else $error("pending trapezoid not delivered in the next cycle");

    // A word without last is always followed by its partner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (trap_valid && !trap.last) |-> pend_valid_reg)
        else $error("first trapezoid strobed without a pending second one");

    // Busy only when every stage ahead of the result port is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (in_valid_reg && srt_valid_reg && pend_valid_reg))
        else $error("busy raised while a stage is free");

    // A split triangle always gives its two words on consecutive result cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_first && two_words) |=> (trap_valid && !trap.last) ##1 (trap_valid && trap.last))
        else $error("split triangle did not give two consecutive trapezoids");

endmodule

/* tb/sv/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 1200;
    localparam int SETTLE_CYCLES = 8;

    // One triangle of stimulus, with its trapezoids typed in where they are obvious.
    typedef struct {
        tts_pkg::tri_in_t vin;
        bit               typed;
        int unsigned      count;
        tts_pkg::trap_t   want [2];
    } tri_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    tts_pkg::tri_in_t vertices;
    logic             trap_valid;
    tts_pkg::trap_t   trap;

    tts_pkg::trap_t traps_due [$];
    tri_row_t       tri_table [$];
    int             mismatch_count;
    int             cycle_count;

    triangle_trapezoid_split i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .vertices   (vertices),
        .trap_valid (trap_valid),
        .trap       (trap)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic tts_pkg::tri_in_t make_tri(int x0, int y0, int x1, int y1,
                                                  int x2, int y2);
        tts_pkg::tri_in_t w;
        w.first_x  = tts_pkg::coord_t'(x0);
        w.first_y  = tts_pkg::coord_t'(y0);
        w.second_x = tts_pkg::coord_t'(x1);
        w.second_y = tts_pkg::coord_t'(y1);
        w.third_x  = tts_pkg::coord_t'(x2);
        w.third_y  = tts_pkg::coord_t'(y2);
        return w;
    endfunction

    function automatic tts_pkg::trap_t make_trap(int top, int bot,
                                                 tts_pkg::vidx_t ls, tts_pkg::vidx_t le,
                                                 tts_pkg::vidx_t rs, tts_pkg::vidx_t re,
                                                 bit fin);
        tts_pkg::trap_t t;
        t.top_y       = tts_pkg::coord_t'(top);
        t.bottom_y    = tts_pkg::coord_t'(bot);
        t.left_start  = ls;
        t.left_end    = le;
        t.right_start = rs;
        t.right_end   = re;
        t.last        = fin;
        return t;
    endfunction

    // Sort by y, drop degenerate triangles, then split into trapezoids.
    function automatic void predict_traps(tts_pkg::tri_in_t w);
        tts_pkg::coord_t xs [3];
        tts_pkg::coord_t ys [3];
        tts_pkg::vidx_t  a;
        tts_pkg::vidx_t  b;
        tts_pkg::vidx_t  c;
        tts_pkg::vidx_t  t;
        longint          lhs;
        longint          rhs;
        xs[0] = w.first_x;
        ys[0] = w.first_y;
        xs[1] = w.second_x;
        ys[1] = w.second_y;
        xs[2] = w.third_x;
        ys[2] = w.third_y;
        a = tts_pkg::VTX_FIRST;
        b = tts_pkg::VTX_SECOND;
        c = tts_pkg::VTX_THIRD;
        // Swap only on strictly greater y; equal y need not keep input order.
        if (ys[a] > ys[b])
        begin
            t = a; a = b; b = t;
        end
        if (ys[a] > ys[c])
        begin
            t = a; a = c; c = t;
        end
        if (ys[b] > ys[c])
        begin
            t = b; b = c; c = t;
        end
        if (ys[a] == ys[b] && ys[b] == ys[c])
            return;
        if (xs[a] == xs[b] && xs[b] == xs[c])
            return;
        // Flat top: order the two upper vertices by x.
        if (ys[a] == ys[b])
        begin
            if (xs[a] > xs[b])
            begin
                t = a; a = b; b = t;
            end
            traps_due.insert(traps_due.size(), make_trap(ys[a], ys[c], a, c, b, c, 1'b1));
            return;
        end
        // Flat bottom: order the two lower vertices by x.
        if (ys[b] == ys[c])
        begin
            if (xs[b] > xs[c])
            begin
                t = b; b = c; c = t;
            end
            traps_due.insert(traps_due.size(), make_trap(ys[a], ys[c], a, b, a, c, 1'b1));
            return;
        end
        // Middle vertex is on the left when the cross products allow it; ties go left.
        lhs = (longint'(xs[b]) - longint'(xs[a])) * (longint'(ys[c]) - longint'(ys[a]));
        rhs = (longint'(xs[c]) - longint'(xs[a])) * (longint'(ys[b]) - longint'(ys[a]));
        if (lhs <= rhs)
        begin
            traps_due.insert(traps_due.size(), make_trap(ys[a], ys[b], a, b, a, c, 1'b0));
            traps_due.insert(traps_due.size(), make_trap(ys[b], ys[c], b, c, a, c, 1'b1));
        end
        else
        begin
            traps_due.insert(traps_due.size(), make_trap(ys[a], ys[b], a, c, a, b, 1'b0));
            traps_due.insert(traps_due.size(), make_trap(ys[b], ys[c], a, c, b, c, 1'b1));
        end
    endfunction

    function automatic void add_row(tts_pkg::tri_in_t vin, bit typed, int unsigned count,
                                    tts_pkg::trap_t w0, tts_pkg::trap_t w1);
        tri_row_t r;
        r.vin     = vin;
        r.typed   = typed;
        r.count   = count;
        r.want[0] = w0;
        r.want[1] = w1;
        tri_table.insert(tri_table.size(), r);
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(0, 8)) - 4;
    endfunction

    // Random triangle drawn from a mix of shapes that reach every branch.
    function automatic tts_pkg::tri_in_t random_triangle();
        int cx [3];
        int cy [3];
        int kind;
        int px;
        int py;
        int dx;
        int dy;
        int i;
        int j;
        int k;
        int tmp;
        kind = $urandom_range(0, 99);
        for (i = 0; i < 3; i++)
        begin
            cx[i] = int'(tts_pkg::coord_t'($urandom));
            cy[i] = int'(tts_pkg::coord_t'($urandom));
        end
        if (kind < 30)
        begin
            // Full-range coordinates as drawn.
        end
        else if (kind < 50)
        begin
            for (i = 0; i < 3; i++)
            begin
                cx[i] = small_coord();
                cy[i] = small_coord();
            end
        end
        else if (kind < 70)
        begin
            // Two vertices share a y: flat top or flat bottom.
            if (kind < 60)
            begin
                for (i = 0; i < 3; i++)
                begin
                    cx[i] = int'($urandom_range(0, 400)) - 200;
                    cy[i] = int'($urandom_range(0, 400)) - 200;
                end
            end
            cy[1] = cy[0];
        end
        else if (kind < 80)
        begin
            // Three points on one line.
            px = int'($urandom_range(0, 2000)) - 1000;
            py = int'($urandom_range(0, 2000)) - 1000;
            dx = int'($urandom_range(0, 400)) - 200;
            dy = int'($urandom_range(0, 400)) - 200;
            k  = int'($urandom_range(0, 6)) - 3;
            cx[0] = px;          cy[0] = py;
            cx[1] = px + dx;     cy[1] = py + dy;
            cx[2] = px + k * dx; cy[2] = py + k * dy;
        end
        else if (kind < 85)
        begin
            cy[1] = cy[0];
            cy[2] = cy[0];
        end
        else if (kind < 90)
        begin
            cx[1] = cx[0];
            cx[2] = cx[0];
        end
        else
        begin
            for (i = 0; i < 3; i++)
            begin
                cx[i] = int'($urandom_range(0, 4095)) - 2048;
                cy[i] = int'($urandom_range(0, 4095)) - 2048;
            end
        end
        // Shuffle the vertex order.
        for (i = 0; i < 2; i++)
        begin
            j = $urandom_range(0, 2);
            k = $urandom_range(0, 2);
            tmp = cx[j]; cx[j] = cx[k]; cx[k] = tmp;
            tmp = cy[j]; cy[j] = cy[k]; cy[k] = tmp;
        end
        return make_tri(cx[0], cy[0], cx[1], cy[1], cx[2], cy[2]);
    endfunction

    // Present one triangle word after a gap and hold it until the block takes it.
    task automatic send_triangle(tri_row_t r, int gap);
        int i;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        vertices <= r.vin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.typed)
        begin
            for (i = 0; i < r.count; i++)
                traps_due.insert(traps_due.size(), r.want[i]);
        end
        else
            predict_traps(r.vin);
    endtask

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each strobed trapezoid with the oldest one due.
    always @(posedge clk)
    begin
        tts_pkg::trap_t w;
        if (rst_n && trap_valid === 1'b1)
        begin
            if (traps_due.size() == 0)
            begin
                $error("unexpected trapezoid word: top_y %0d bottom_y %0d",
                       trap.top_y, trap.bottom_y);
                mismatch_count++;
            end
            else
            begin
                w = traps_due.pop_front();
                check_field("top_y", w.top_y, trap.top_y);
                check_field("bottom_y", w.bottom_y, trap.bottom_y);
                check_field("left_start", w.left_start, trap.left_start);
                check_field("left_end", w.left_end, trap.left_end);
                check_field("right_start", w.right_start, trap.right_start);
                check_field("right_end", w.right_end, trap.right_end);
                check_field("last", w.last, trap.last);
            end
        end
    end

    // Main sequence: reset, directed table, random triangles, drain.
    initial
    begin
        tri_row_t       r;
        tts_pkg::trap_t none;
        int             i;
        int             gap;
        none     = '0;
        rst_n    = 1'b0;
        start    = 1'b0;
        vertices = '0;

        // Degenerate triangles give no word.
        add_row(make_tri(0, 0, 0, 0, 0, 0), 1'b1, 0, none, none);
        add_row(make_tri(-32768, -32768, 0, -32768, 32767, -32768), 1'b1, 0, none, none);
        add_row(make_tri(32767, -32768, 32767, 0, 32767, 32767), 1'b1, 0, none, none);
        add_row(make_tri(-1, -1, -1, -1, -1, -1), 1'b1, 0, none, none);
        // Flat top, in x order and swapped.
        add_row(make_tri(0, 0, 16, 0, 8, 32), 1'b1, 1,
                make_trap(0, 32, tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_SECOND, tts_pkg::VTX_THIRD, 1'b1), none);
        add_row(make_tri(16, 0, 0, 0, 8, 32), 1'b1, 1,
                make_trap(0, 32, tts_pkg::VTX_SECOND, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b1), none);
        // Flat bottom, in x order and swapped.
        add_row(make_tri(8, 0, 0, 32, 16, 32), 1'b1, 1,
                make_trap(0, 32, tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b1), none);
        add_row(make_tri(8, 0, 16, 32, 0, 32), 1'b1, 1,
                make_trap(0, 32, tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND, 1'b1), none);
        // Middle vertex on the left, then on the right.
        add_row(make_tri(0, 0, -16, 16, 0, 32), 1'b1, 2,
                make_trap(0, 16, tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b0),
                make_trap(16, 32, tts_pkg::VTX_SECOND, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b1));
        add_row(make_tri(0, 0, 16, 16, 0, 32), 1'b1, 2,
                make_trap(0, 16, tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND, 1'b0),
                make_trap(16, 32, tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_SECOND, tts_pkg::VTX_THIRD, 1'b1));
        // Collinear but not vertical: middle vertex counts as left.
        add_row(make_tri(0, 0, 16, 16, 32, 32), 1'b1, 2,
                make_trap(0, 16, tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b0),
                make_trap(16, 32, tts_pkg::VTX_SECOND, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD, 1'b1));
        // Extreme corners as a flat bottom.
        add_row(make_tri(-32768, -32768, 32767, 32767, -32768, 32767), 1'b1, 1,
                make_trap(-32768, 32767, tts_pkg::VTX_FIRST, tts_pkg::VTX_THIRD,
                          tts_pkg::VTX_FIRST, tts_pkg::VTX_SECOND, 1'b1),
                none);
        // Remaining rows go through the predictor.
        add_row(make_tri(32767, -32768, -32768, 0, 32767, 32767), 1'b0, 0, none, none);
        add_row(make_tri(-32768, 32767, 32767, -32768, 0, 0), 1'b0, 0, none, none);
        add_row(make_tri(0, 32, 16, 16, -16, 0), 1'b0, 0, none, none);
        add_row(make_tri(0, 48, 10, 32, -20, 16), 1'b0, 0, none, none);
        add_row(make_tri(5, 5, 5, 5, 100, 200), 1'b0, 0, none, none);
        add_row(make_tri(100, 200, 5, 5, 5, 5), 1'b0, 0, none, none);
        add_row(make_tri(7, 10, 3, 20, 9, 10), 1'b0, 0, none, none);
        add_row(make_tri(3, 20, 7, 10, 9, 20), 1'b0, 0, none, none);
        add_row(make_tri(32767, 32767, -32768, -32768, 0, 32767), 1'b0, 0, none, none);
        add_row(make_tri(16'sh5555, -21846, -21846, 16'sh5555, 0, -1), 1'b0, 0, none, none);
        add_row(make_tri(-21846, -1, 16'sh5555, 0, -1, -21846), 1'b0, 0, none, none);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (tri_table[n])
            send_triangle(tri_table[n], $urandom_range(0, 4));

        r.typed = 1'b0;
        r.count = 0;
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            // Some stretches run back to back with no gaps.
            gap = ((i / 100) % 3 == 1) ? 0 : $urandom_range(0, 4);
            // Once, let the block drain completely before going on.
            if (i == RANDOM_WORDS / 2)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (traps_due.size() != 0)
                    @(posedge clk);
                repeat (SETTLE_CYCLES) @(posedge clk);
            end
            r.vin = random_triangle();
            send_triangle(r, gap);
        end
        @(negedge clk);
        start <= 1'b0;

        while (traps_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && traps_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* triangle_trapezoid_split.f */
hw/rtl/tts_pkg.sv
hw/rtl/triangle_trapezoid_split.sv
tb/sv/testbench.sv
